// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the tokenizer queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GTT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GTT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GTT_ASSERT(lbl, clk, rst_n, prop, msg)
`define GTT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/gtt_pkg.sv =====
// Types, constants and keyword table of the grammar text tokenizer.
package gtt_pkg;
	localparam int POS_BITS    = 24;
	localparam int NEST_BITS   = 8;
	localparam int KEYWORD_MAX = 8;
	localparam int KW_BITS     = KEYWORD_MAX * 8;
	localparam int KC_BITS     = $clog2(KEYWORD_MAX + 2);
	localparam int OUT_W       = 24;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR       = $clog2(Q_DEPTH);

	localparam logic [NEST_BITS-1:0] NEST_MAX = {NEST_BITS{1'b1}};

	localparam logic [4:0] K_EOI      = 5'd0;
	localparam logic [4:0] K_IDENT    = 5'd1;
	localparam logic [4:0] K_QUAL     = 5'd2;
	localparam logic [4:0] K_STRING   = 5'd3;
	localparam logic [4:0] K_ARG      = 5'd4;
	localparam logic [4:0] K_CODE     = 5'd5;
	localparam logic [4:0] K_EQUAL    = 5'd6;
	localparam logic [4:0] K_COLON    = 5'd7;
	localparam logic [4:0] K_COMMA    = 5'd8;
	localparam logic [4:0] K_SEMI     = 5'd9;
	localparam logic [4:0] K_PIPE     = 5'd10;
	localparam logic [4:0] K_LPAREN   = 5'd11;
	localparam logic [4:0] K_RPAREN   = 5'd12;
	localparam logic [4:0] K_RP_OPT   = 5'd13;
	localparam logic [4:0] K_RP_STAR  = 5'd14;
	localparam logic [4:0] K_RP_PLUS  = 5'd15;
	localparam logic [4:0] K_PCTPCT   = 5'd16;
	localparam logic [4:0] K_KW_FIRST = 5'd17;
	localparam logic [4:0] K_UNKNOWN  = 5'd23;

	localparam logic [2:0] E_NONE    = 3'd0;
	localparam logic [2:0] E_KEYWORD = 3'd1;
	localparam logic [2:0] E_CODE    = 3'd2;
	localparam logic [2:0] E_STRING  = 3'd3;
	localparam logic [2:0] E_COMMENT = 3'd4;

	localparam int KW_COUNT = 6;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_SLASH, M_LINE, M_BLOCK, M_STAR, M_STRING,
		M_CODE_FIRST, M_CODE, M_RPAREN, M_PERCENT, M_KEYWORD
	} mode_t;

	typedef struct packed {
		logic [4:0]       kind;
		logic [OUT_W-1:0] start;
		logic [OUT_W-1:0] length;
		logic [2:0]       err;
	} tok_t;

	// one queue entry holds every token that one byte causes
	typedef struct packed {
		logic two;
		tok_t t0;
		tok_t t1;
	} entry_t;

	function automatic logic [KC_BITS-1:0] kw_len(input logic [2:0] i);
		case (i)
			3'd0:    kw_len = KC_BITS'(3);
			3'd1:    kw_len = KC_BITS'(6);
			3'd2:    kw_len = KC_BITS'(2);
			3'd3:    kw_len = KC_BITS'(8);
			3'd4:    kw_len = KC_BITS'(5);
			3'd5:    kw_len = KC_BITS'(5);
			default: kw_len = '0;
		endcase
	endfunction

	// name bytes little end first, zero padded
	function automatic logic [KW_BITS-1:0] kw_name(input logic [2:0] i);
		case (i)
			3'd0:    kw_name = KW_BITS'(64'h0000_0000_0069_6f65);
			3'd1:    kw_name = KW_BITS'(64'h0000_656e_6966_6564);
			3'd2:    kw_name = KW_BITS'(64'h0000_0000_0000_6669);
			3'd3:    kw_name = KW_BITS'(64'h6567_6175_676e_616c);
			3'd4:    kw_name = KW_BITS'(64'h0000_0074_7261_7473);
			3'd5:    kw_name = KW_BITS'(64'h0000_006e_656b_6f74);
			default: kw_name = '0;
		endcase
	endfunction

	function automatic tok_t mk(input logic [4:0] k, input logic [POS_BITS-1:0] s,
			input logic [POS_BITS-1:0] l, input logic [2:0] e);
		tok_t t;
		t.kind   = k;
		t.start  = OUT_W'(s);
		t.length = OUT_W'(l);
		t.err    = e;
		return t;
	endfunction
endpackage

// ===== rtl/core/gtt_front.sv =====
// Front end: lexer state machine that classifies bytes and builds token entries.
module gtt_front import gtt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] in_byte,
	output logic       wr,
	output entry_t     wr_entry
);
	mode_t                 mode_q, mode_d;
	logic [POS_BITS-1:0]   pos_q, pos_d, begin_q, begin_d;
	logic [NEST_BITS-1:0]  nest_q, nest_d;
	logic                  dq_q, dq_d, brace_q, brace_d, dotf_q, dotf_d;
	logic                  prev_q, prev_d, sdot_q, sdot_d;
	logic [KW_BITS-1:0]    kch_q, kch_d;
	logic [KC_BITS-1:0]    kcnt_q, kcnt_d;

	tok_t                  r [2];
	logic [1:0]            nres;
	logic                  ended, do_idle, letter, alnum;
	logic [POS_BITS-1:0]   len;
	logic [4:0]            ckind;
	logic [7:0]            copen, cclose;

	assign letter = (in_byte >= 8'h41 && in_byte <= 8'h5a) ||
		(in_byte >= 8'h61 && in_byte <= 8'h7a);
	assign alnum  = letter || (in_byte >= 8'h30 && in_byte <= 8'h39);
	assign len    = pos_q - begin_q;
	assign ckind  = brace_q ? K_CODE : K_ARG;
	assign copen  = brace_q ? 8'h7b : 8'h3c;
	assign cclose = brace_q ? 8'h7d : 8'h3e;

	always_comb begin
		logic [4:0] kk;
		logic [2:0] ke;
		kk = K_UNKNOWN;
		ke = E_KEYWORD;
		mode_d  = mode_q;
		pos_d   = pos_q;
		begin_d = begin_q;
		nest_d  = nest_q;
		dq_d    = dq_q;
		brace_d = brace_q;
		dotf_d  = dotf_q;
		prev_d  = prev_q;
		sdot_d  = sdot_q;
		kch_d   = kch_q;
		kcnt_d  = kcnt_q;
		r[0]    = '0;
		r[1]    = '0;
		nres    = 2'd0;
		ended   = 1'b0;
		do_idle = 1'b0;

		case (mode_q)
			M_IDENT: begin
				if (alnum || in_byte == 8'h5f || in_byte == 8'h2e) begin
					if (in_byte == 8'h2e)
						sdot_d = 1'b1;
				end else begin
					r[0] = mk(sdot_q ? K_QUAL : K_IDENT, begin_q, len, E_NONE);
					nres = 2'd1;
					do_idle = 1'b1;
				end
			end
			M_SLASH: begin
				if (in_byte == 8'h2a)
					mode_d = M_BLOCK;
				else if (in_byte == 8'h2f)
					mode_d = M_LINE;
				else begin
					r[0] = mk(K_UNKNOWN, begin_q, POS_BITS'(1), E_NONE);
					nres = 2'd1;
					do_idle = 1'b1;
				end
			end
			M_LINE: begin
				if (in_byte == 8'h00) begin
					r[0] = mk(K_EOI, pos_q, '0, E_NONE);
					nres = 2'd1;
					ended = 1'b1;
				end else if (in_byte == 8'h0a || in_byte == 8'h0d)
					mode_d = M_IDLE;
			end
			M_BLOCK, M_STAR: begin
				if (in_byte == 8'h00) begin
					r[0] = mk(K_EOI, pos_q, '0, E_COMMENT);
					nres = 2'd1;
					ended = 1'b1;
				end else if (in_byte == 8'h2a)
					mode_d = M_STAR;
				else if (in_byte == 8'h2f && mode_q == M_STAR)
					mode_d = M_IDLE;
				else
					mode_d = M_BLOCK;
			end
			M_STRING: begin
				if (in_byte == 8'h00) begin
					r[0] = mk(K_STRING, begin_q, len, E_STRING);
					r[1] = mk(K_EOI, pos_q, '0, E_NONE);
					nres = 2'd2;
					ended = 1'b1;
				end else if (in_byte == (dq_q ? 8'h22 : 8'h27)) begin
					r[0] = mk(K_STRING, begin_q, len + 1'b1, E_NONE);
					nres = 2'd1;
					mode_d = M_IDLE;
				end else if (in_byte == 8'h0a || in_byte == 8'h0d) begin
					r[0] = mk(K_STRING, begin_q, len + 1'b1, E_STRING);
					nres = 2'd1;
					mode_d = M_IDLE;
				end
			end
			M_CODE_FIRST, M_CODE: begin
				mode_d = M_CODE;
				if (mode_q == M_CODE_FIRST && in_byte == 8'h2e) begin
					dotf_d = 1'b1;
					prev_d = 1'b1;
				end else if (in_byte == 8'h00) begin
					r[0] = mk(ckind, begin_q, len, E_CODE);
					r[1] = mk(K_EOI, pos_q, '0, E_NONE);
					nres = 2'd2;
					ended = 1'b1;
				end else if (dotf_q) begin
					if (in_byte == cclose && prev_q) begin
						r[0] = mk(ckind, begin_q, len + 1'b1, E_NONE);
						nres = 2'd1;
						mode_d = M_IDLE;
					end else
						prev_d = (in_byte == 8'h2e);
				end else if (in_byte == cclose) begin
					nest_d = nest_q - 1'b1;
					if (nest_d == '0) begin
						r[0] = mk(ckind, begin_q, len + 1'b1, E_NONE);
						nres = 2'd1;
						mode_d = M_IDLE;
					end
				end else if (in_byte == copen) begin
					if (nest_q == NEST_MAX) begin
						// nesting overflow closes the block here
						r[0] = mk(ckind, begin_q, len + 1'b1, E_CODE);
						nres = 2'd1;
						nest_d = '0;
						mode_d = M_IDLE;
					end else
						nest_d = nest_q + 1'b1;
				end
			end
			M_RPAREN: begin
				if (in_byte == 8'h3f || in_byte == 8'h2a || in_byte == 8'h2b) begin
					if (in_byte == 8'h3f)
						kk = K_RP_OPT;
					else if (in_byte == 8'h2a)
						kk = K_RP_STAR;
					else
						kk = K_RP_PLUS;
					r[0] = mk(kk, begin_q, POS_BITS'(2), E_NONE);
					nres = 2'd1;
					mode_d = M_IDLE;
				end else begin
					r[0] = mk(K_RPAREN, begin_q, POS_BITS'(1), E_NONE);
					nres = 2'd1;
					do_idle = 1'b1;
				end
			end
			M_PERCENT, M_KEYWORD: begin
				if (mode_q == M_PERCENT && in_byte == 8'h25) begin
					r[0] = mk(K_PCTPCT, begin_q, POS_BITS'(2), E_NONE);
					nres = 2'd1;
					mode_d = M_IDLE;
				end else begin
					mode_d = M_KEYWORD;
					if (mode_q == M_PERCENT) begin
						kch_d  = '0;
						kcnt_d = '0;
					end
					if (alnum) begin
						if (kcnt_d < KC_BITS'(KEYWORD_MAX))
							kch_d[kcnt_d[$clog2(KEYWORD_MAX)-1:0]*8 +: 8] = in_byte;
						if (kcnt_d <= KC_BITS'(KEYWORD_MAX))
							kcnt_d = kcnt_d + 1'b1;
					end else begin
						for (int i = 0; i < KW_COUNT; i++) begin
							if (kcnt_d == kw_len(3'(i)) && kch_d == kw_name(3'(i))) begin
								kk = K_KW_FIRST + 5'(i);
								ke = E_NONE;
							end
						end
						r[0] = mk(kk, begin_q, len, ke);
						nres = 2'd1;
						kch_d  = '0;
						kcnt_d = '0;
						do_idle = 1'b1;
					end
				end
			end
			default: do_idle = 1'b1;
		endcase

		if (do_idle) begin
			mode_d = M_IDLE;
			if (in_byte == 8'h00) begin
				r[nres[0]] = mk(K_EOI, pos_q, '0, E_NONE);
				nres = nres + 1'b1;
				ended = 1'b1;
			end else if (!(in_byte == 8'h0d || in_byte == 8'h0a || in_byte == 8'h20 ||
					in_byte == 8'h09 || in_byte == 8'h0c || in_byte == 8'h0b)) begin
				begin_d = pos_q;
				kk = 5'd0;
				case (in_byte)
					8'h3d: kk = K_EQUAL;
					8'h3a: kk = K_COLON;
					8'h2c: kk = K_COMMA;
					8'h3b: kk = K_SEMI;
					8'h7c: kk = K_PIPE;
					8'h28: kk = K_LPAREN;
					8'h2f: mode_d = M_SLASH;
					8'h22, 8'h27: begin
						dq_d = (in_byte == 8'h22);
						mode_d = M_STRING;
					end
					8'h3c, 8'h7b: begin
						brace_d = (in_byte == 8'h7b);
						nest_d  = NEST_BITS'(1);
						dotf_d  = 1'b0;
						prev_d  = 1'b0;
						mode_d  = M_CODE_FIRST;
					end
					8'h29: mode_d = M_RPAREN;
					8'h25: mode_d = M_PERCENT;
					default: kk = K_UNKNOWN;
				endcase
				if (letter) begin
					kk = 5'd0;
					sdot_d = 1'b0;
					mode_d = M_IDENT;
				end
				if (kk != 5'd0) begin
					r[nres[0]] = mk(kk, pos_q, POS_BITS'(1), E_NONE);
					nres = nres + 1'b1;
				end
			end
		end

		if (ended) begin
			mode_d  = M_IDLE;
			pos_d   = '0;
			begin_d = '0;
			nest_d  = '0;
			dq_d    = 1'b0;
			brace_d = 1'b0;
			dotf_d  = 1'b0;
			prev_d  = 1'b0;
			sdot_d  = 1'b0;
			kch_d   = '0;
			kcnt_d  = '0;
		end else
			pos_d = pos_q + 1'b1;
	end

	assign wr          = take && (nres != 2'd0);
	assign wr_entry.two = nres[1];
	assign wr_entry.t0 = r[0];
	assign wr_entry.t1 = r[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			nest_q  <= '0;
			dq_q    <= 1'b0;
			brace_q <= 1'b0;
			dotf_q  <= 1'b0;
			prev_q  <= 1'b0;
			sdot_q  <= 1'b0;
			kch_q   <= '0;
			kcnt_q  <= '0;
		end else if (take) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			begin_q <= begin_d;
			nest_q  <= nest_d;
			dq_q    <= dq_d;
			brace_q <= brace_d;
			dotf_q  <= dotf_d;
			prev_q  <= prev_d;
			sdot_q  <= sdot_d;
			kch_q   <= kch_d;
			kcnt_q  <= kcnt_d;
		end
	end
endmodule

// ===== rtl/core/gtt_queue.sv =====
// Short entry queue between the lexer front and the token output.
`include "assert_macros.svh"
module gtt_queue import gtt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  entry_t wr_entry,
	input  logic   rd,
	output entry_t rd_entry,
	output logic   full,
	output logic   empty
);
	entry_t             mem [Q_DEPTH];
	logic [Q_PTR-1:0]   wp_q, rp_q;
	logic [Q_PTR:0]     cnt_q;
	logic               do_wr, do_rd;

	assign full     = (cnt_q == (Q_PTR+1)'(Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_wr    = wr && !full;
	assign do_rd    = rd && !empty;
	assign rd_entry = mem[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem[wp_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + 1'b1;
			if (do_rd)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (Q_PTR+1)'(do_wr) - (Q_PTR+1)'(do_rd);
		end
	end

	`GTT_NEVER(a_cnt_range, clk, arst_n, cnt_q > (Q_PTR+1)'(Q_DEPTH), "queue count overflow")
	`GTT_ASSERT(a_cnt_up, clk, arst_n, do_wr && !do_rd |=> cnt_q == $past(cnt_q) + 1'b1, "queue count did not rise")
	`GTT_ASSERT(a_ptr_gap, clk, arst_n, (Q_PTR)'(wp_q - rp_q) == cnt_q[Q_PTR-1:0], "queue pointers disagree with count")
endmodule

// ===== rtl/core/gtt_back.sv =====
// Back end: hands out the one or two tokens of each queue entry in order.
module gtt_back import gtt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  logic       q_empty,
	input  logic       pop,
	output logic       q_rd,
	output logic [4:0] token_kind,
	output logic [OUT_W-1:0] token_start,
	output logic [OUT_W-1:0] token_length,
	output logic [2:0] error_code,
	output logic       last_of_run
);
	logic sel_q;
	tok_t cur;

	assign cur          = sel_q ? head.t1 : head.t0;
	assign token_kind   = cur.kind;
	assign token_start  = cur.start;
	assign token_length = cur.length;
	assign error_code   = cur.err;
	assign last_of_run  = sel_q || !head.two;
	assign q_rd         = pop && !q_empty && last_of_run;

	// advance to the second token, or drop the entry after its last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sel_q <= 1'b0;
		else if (pop && !q_empty)
			sel_q <= !last_of_run;
	end
endmodule

// ===== rtl/core/grammar_text_tokenizer.sv =====
// Grammar text tokenizer: takes one text byte per cycle (0 ends the input) and
// yields kind, start, length and error of each token. A byte is taken in each
// cycle with push high and full low; the token that a byte completes is written
// to the queue as that byte is taken. One byte can yield two tokens, and those
// leave the output one per cycle while pop is high, so a burst of such bytes is
// paced by the result side and the four-entry queue between the lexer and the output.
module grammar_text_tokenizer import gtt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       in_byte,
	output logic             empty,
	input  logic             pop,
	output logic [4:0]       token_kind,
	output logic [OUT_W-1:0] token_start,
	output logic [OUT_W-1:0] token_length,
	output logic [2:0]       error_code,
	output logic             last_of_run
);
	logic   wr, rd;
	entry_t wr_entry, head;

	gtt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (push && !full),
		.in_byte  (in_byte),
		.wr       (wr),
		.wr_entry (wr_entry)
	);

	gtt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_entry (wr_entry),
		.rd       (rd),
		.rd_entry (head),
		.full     (full),
		.empty    (empty)
	);

	gtt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (empty),
		.pop          (pop),
		.q_rd         (rd),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);
endmodule
